@@ design/battery_fuel_gauge_filter_defines.svh @@
// Assertion helpers shared by the fuel gauge modules.
`ifndef BATTERY_FUEL_GAUGE_FILTER_DEFINES_SVH
`define BATTERY_FUEL_GAUGE_FILTER_DEFINES_SVH

// Checked on every rising edge of clk_i, ignored while reset is asserted.
`define BFG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define BFG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/bfg_pkg.sv @@
package bfg_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 18;
  localparam int MV_W       = 14;
  localparam int GAIN_W     = 16;
  localparam int VF_W       = 22;
  localparam int PF_W       = 15;
  localparam int PCT_W      = 7;
  localparam int ALPHA_W    = 8;
  localparam int SETTLE_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CURVE_N    = 19;
  localparam int SEG_W      = 5;
  localparam int MVD_W      = 7;
  localparam int DP_W       = 4;
  localparam int RECIP_W    = 15;
  localparam int RECIP_SH   = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_ON  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_OFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY      = 3'd5;

  localparam logic [ALPHA_W-1:0] AV_CHARGE = 8'd64;
  localparam logic [ALPHA_W-1:0] AV_DISCH  = 8'd31;
  localparam logic [ALPHA_W-1:0] AV_SETTLE = 8'd13;
  localparam logic [ALPHA_W-1:0] AP_CHARGE = 8'd51;
  localparam logic [ALPHA_W-1:0] AP_DISCH  = 8'd38;
  localparam logic [ALPHA_W-1:0] AP_SETTLE = 8'd15;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [MV_W-1:0]  MV_MAX  = 14'd16383;

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_N] = '{
    14'd4050, 14'd4000, 14'd3950, 14'd3900, 14'd3850, 14'd3800, 14'd3750,
    14'd3700, 14'd3650, 14'd3600, 14'd3550, 14'd3500, 14'd3450, 14'd3400,
    14'd3350, 14'd3300, 14'd3200, 14'd3100, 14'd3000};
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_N] = '{
    7'd100, 7'd98, 7'd95, 7'd90, 7'd82, 7'd70, 7'd62, 7'd54, 7'd45, 7'd35,
    7'd27, 7'd20, 7'd14, 7'd10, 7'd7, 7'd5, 7'd2, 7'd1, 7'd0};

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_FIX, ST_GAIN, ST_MODE, ST_VMUL, ST_VEMA,
    ST_CURVE, ST_CMUL, ST_CDIV, ST_PMUL, ST_PEMA, ST_SLEW, ST_OUT
  } bfg_state_e;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] sm0;
    logic [SAMPLE_W-1:0] sm1;
    logic [SAMPLE_W-1:0] lg0;
    logic [SAMPLE_W-1:0] lg1;
  } bfg_entry_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [MV_W-1:0]     on_mv;
    logic [MV_W-1:0]     off_mv;
    logic [SETTLE_W-1:0] settle;
    logic [MV_W-1:0]     full_mv;
    logic [MV_W-1:0]     empty_mv;
  } bfg_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bfg_qstat_t;

  // Q20 reciprocal of a curve segment's width in mV, exact for every
  // rounded quotient this curve can produce.
  function automatic logic [RECIP_W-1:0] seg_recip(input logic [MVD_W-1:0] mvd);
    logic [RECIP_W-1:0] r;
    case (mvd)
      7'd50:   r = 15'd20972;
      7'd100:  r = 15'd10486;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/battery_fuel_gauge_filter.sv @@
// Voltage fuel gauge: ADC samples (mV at the pin) enter one item per cycle
// and every SAMPLES_PER_READING samples form a reading; the front stage keeps
// the running sum and the extreme samples and hands the reading to a
// two-entry queue, and a sequencer in the back stage turns it into one result
// (trimmed mean, gain, charge detection, voltage filter, curve lookup, percent
// filter with slew limit). Samples are stalled only while the queue holds two
// finished readings. Configuration writes take effect at once and are meant
// for idle periods.
module battery_fuel_gauge_filter #(
  parameter int SAMPLES_PER_READING = 16,
  parameter int TRIM_EACH_SIDE      = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bfg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bfg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bfg_pkg::SAMPLE_W-1:0]    sample_mv_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bfg_pkg::PCT_W-1:0]       charge_percent_o,
  output logic                            charging_o,
  output logic [bfg_pkg::MV_W-1:0]        measured_mv_o
);

  bfg_pkg::bfg_cfg_t   cfg_q;
  bfg_pkg::bfg_entry_t push_entry, head_entry;
  bfg_pkg::bfg_qstat_t qstat;
  logic                push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain     <= 16'd49152;
      cfg_q.on_mv    <= 14'd4000;
      cfg_q.off_mv   <= 14'd3950;
      cfg_q.settle   <= 8'd36;
      cfg_q.full_mv  <= 14'd4050;
      cfg_q.empty_mv <= 14'd3000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bfg_pkg::CFG_GAIN:       cfg_q.gain     <= cfg_wdata_i;
        bfg_pkg::CFG_CHARGE_ON:  cfg_q.on_mv    <= cfg_wdata_i[bfg_pkg::MV_W-1:0];
        bfg_pkg::CFG_CHARGE_OFF: cfg_q.off_mv   <= cfg_wdata_i[bfg_pkg::MV_W-1:0];
        bfg_pkg::CFG_SETTLE:     cfg_q.settle   <= cfg_wdata_i[bfg_pkg::SETTLE_W-1:0];
        bfg_pkg::CFG_FULL:       cfg_q.full_mv  <= cfg_wdata_i[bfg_pkg::MV_W-1:0];
        bfg_pkg::CFG_EMPTY:      cfg_q.empty_mv <= cfg_wdata_i[bfg_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  bfg_front #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_mv_i (sample_mv_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  bfg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  bfg_back #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING),
    .TRIM_EACH_SIDE     (TRIM_EACH_SIDE)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .entry_i          (head_entry),
    .qstat_i          (qstat),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .charge_percent_o (charge_percent_o),
    .charging_o       (charging_o),
    .measured_mv_o    (measured_mv_o)
  );

endmodule

@@ design/bfg_front.sv @@
module bfg_front #(
  parameter int SAMPLES_PER_READING = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bfg_pkg::SAMPLE_W-1:0]   sample_mv_i,
  input  bfg_pkg::bfg_qstat_t            qstat_i,
  output logic                           push_o,
  output bfg_pkg::bfg_entry_t            entry_o
);

  localparam int IDX_W = $clog2(SAMPLES_PER_READING);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_READING - 1);

  logic [IDX_W-1:0]             idx_q;
  logic [bfg_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [bfg_pkg::SAMPLE_W-1:0] sm0_q, sm1_q, lg0_q, lg1_q;
  logic [bfg_pkg::SAMPLE_W-1:0] sm0_d, sm1_d, lg0_d, lg1_d;
  logic                         accept, last;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign last       = (idx_q == LAST_IDX);

  always_comb begin
    sum_d = sum_q + bfg_pkg::SUM_W'(sample_mv_i);
    sm0_d = sm0_q;
    sm1_d = sm1_q;
    lg0_d = lg0_q;
    lg1_d = lg1_q;
    if (sample_mv_i < sm0_q) begin
      sm1_d = sm0_q;
      sm0_d = sample_mv_i;
    end else if (sample_mv_i < sm1_q) begin
      sm1_d = sample_mv_i;
    end
    if (sample_mv_i > lg0_q) begin
      lg1_d = lg0_q;
      lg0_d = sample_mv_i;
    end else if (sample_mv_i > lg1_q) begin
      lg1_d = sample_mv_i;
    end
  end

  assign push_o  = accept && last;
  assign entry_o = '{sum: sum_d, sm0: sm0_d, sm1: sm1_d, lg0: lg0_d, lg1: lg1_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
      sm0_q <= '1;
      sm1_q <= '1;
      lg0_q <= '0;
      lg1_q <= '0;
    end else if (accept) begin
      if (last) begin
        idx_q <= '0;
        sum_q <= '0;
        sm0_q <= '1;
        sm1_q <= '1;
        lg0_q <= '0;
        lg1_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
        sum_q <= sum_d;
        sm0_q <= sm0_d;
        sm1_q <= sm1_d;
        lg0_q <= lg0_d;
        lg1_q <= lg1_d;
      end
    end
  end

endmodule

@@ design/bfg_fifo.sv @@
`include "battery_fuel_gauge_filter_defines.svh"

module bfg_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bfg_pkg::bfg_entry_t entry_i,
  input  logic                pop_i,
  output bfg_pkg::bfg_entry_t entry_o,
  output bfg_pkg::bfg_qstat_t qstat_o
);

  bfg_pkg::bfg_entry_t mem_q [2];
  logic                wr_q, rd_q;
  logic [1:0]          count_q;

  assign qstat_o.full  = (count_q == 2'd2);
  assign qstat_o.empty = (count_q == 2'd0);
  assign entry_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `BFG_ASSERT(a_no_overflow, push_i |-> (count_q != 2'd2), "item pushed into a full queue")
  `BFG_ASSERT(a_no_underflow, pop_i |-> (count_q != 2'd0), "item popped from an empty queue")
  `BFG_ASSERT_ALWAYS(a_count_range, !rst_ni || (count_q != 2'd3), "queue count out of range")

endmodule

@@ design/bfg_back.sv @@
`include "battery_fuel_gauge_filter_defines.svh"

module bfg_back #(
  parameter int SAMPLES_PER_READING = 16,
  parameter int TRIM_EACH_SIDE      = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfg_pkg::bfg_cfg_t             cfg_i,
  input  bfg_pkg::bfg_entry_t           entry_i,
  input  bfg_pkg::bfg_qstat_t           qstat_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bfg_pkg::PCT_W-1:0]     charge_percent_o,
  output logic                          charging_o,
  output logic [bfg_pkg::MV_W-1:0]      measured_mv_o
);

  localparam int SUM_W  = bfg_pkg::SUM_W;
  localparam int USED   = SAMPLES_PER_READING - 2 * TRIM_EACH_SIDE;
  localparam int RECIP  = (2 ** SUM_W) / USED;
  localparam logic [SUM_W:0]   RECIP_V = (SUM_W + 1)'(RECIP);
  localparam logic [SUM_W-1:0] USED_V  = SUM_W'(USED);

  bfg_pkg::bfg_state_e state_q, state_d;

  logic [SUM_W-1:0]                trim_q;
  logic [bfg_pkg::SAMPLE_W-1:0]    avg_q;
  logic [bfg_pkg::MV_W-1:0]        meas_q;
  logic [bfg_pkg::ALPHA_W-1:0]     av_q, ap_q;
  logic [28:0]                     vmul_q;
  logic [bfg_pkg::VF_W-1:0]        volt_q;
  logic                            direct_q;
  logic [bfg_pkg::PCT_W-1:0]       rawd_q, plo_q, raw_q;
  logic [14:0]                     diff_q;
  logic [bfg_pkg::DP_W-1:0]        dp_q;
  logic [bfg_pkg::MVD_W-1:0]       mvd_q;
  logic [18:0]                     num_q;
  logic [20:0]                     pmul_q;
  logic [bfg_pkg::PF_W-1:0]        pct_q;
  logic [bfg_pkg::PCT_W-1:0]       shown_q;
  logic                            charge_q, primed_q, out_valid_q, out_chg_q;
  logic [bfg_pkg::SETTLE_W-1:0]    settle_q;

  logic                            commit;
  logic [SUM_W-1:0]                trim_c, rem_c;
  logic [2*SUM_W:0]                div_c;
  logic [28:0]                     gain_c;
  logic [bfg_pkg::MV_W-1:0]        meas_c;
  logic                            charge_c, settle_c;
  logic [bfg_pkg::SETTLE_W-1:0]    cnt_c;
  logic [31:0]                     vema_c;
  logic [bfg_pkg::VF_W-1:0]        disp_c, vmax_c, vmin_c;
  logic [bfg_pkg::SEG_W-1:0]       seg_c, seg1_c;
  logic [19:0]                     yr_c;
  logic [26:0]                     q_c;
  logic [24:0]                     pema_c;
  logic [15:0]                     base_c;
  logic [bfg_pkg::PF_W-1:0]        slew_c;
  logic [7:0]                      shown_c;

  // Control outputs of the sequencer.
  always_comb begin
    pop_o  = (state_q == bfg_pkg::ST_IDLE) && !qstat_i.empty;
    commit = (state_q == bfg_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfg_pkg::ST_IDLE:  if (pop_o) state_d = bfg_pkg::ST_DIV;
      bfg_pkg::ST_DIV:   state_d = bfg_pkg::ST_FIX;
      bfg_pkg::ST_FIX:   state_d = bfg_pkg::ST_GAIN;
      bfg_pkg::ST_GAIN:  state_d = bfg_pkg::ST_MODE;
      bfg_pkg::ST_MODE:  state_d = bfg_pkg::ST_VMUL;
      bfg_pkg::ST_VMUL:  state_d = bfg_pkg::ST_VEMA;
      bfg_pkg::ST_VEMA:  state_d = bfg_pkg::ST_CURVE;
      bfg_pkg::ST_CURVE: state_d = bfg_pkg::ST_CMUL;
      bfg_pkg::ST_CMUL:  state_d = bfg_pkg::ST_CDIV;
      bfg_pkg::ST_CDIV:  state_d = bfg_pkg::ST_PMUL;
      bfg_pkg::ST_PMUL:  state_d = bfg_pkg::ST_PEMA;
      bfg_pkg::ST_PEMA:  state_d = bfg_pkg::ST_SLEW;
      bfg_pkg::ST_SLEW:  state_d = bfg_pkg::ST_OUT;
      bfg_pkg::ST_OUT:   if (commit) state_d = bfg_pkg::ST_IDLE;
      default:           state_d = bfg_pkg::ST_IDLE;
    endcase
  end

  // Trimmed sum of the reading at the head of the queue.
  always_comb begin
    trim_c = entry_i.sum;
    if (TRIM_EACH_SIDE >= 1) begin
      trim_c = trim_c - SUM_W'(entry_i.sm0) - SUM_W'(entry_i.lg0);
    end
    if (TRIM_EACH_SIDE >= 2) begin
      trim_c = trim_c - SUM_W'(entry_i.sm1) - SUM_W'(entry_i.lg1);
    end
  end

  // The reciprocal estimate is at most one below the true quotient.
  assign div_c = trim_q * RECIP_V;
  assign rem_c = trim_q - SUM_W'(avg_q) * USED_V;

  always_comb begin
    gain_c = 29'(avg_q) * 29'(cfg_i.gain) + 29'd8192;
    meas_c = gain_c[28] ? bfg_pkg::MV_MAX : gain_c[27:14];
  end

  always_comb begin
    charge_c = charge_q;
    if (charge_q) begin
      if (meas_q < cfg_i.off_mv) charge_c = 1'b0;
    end else if (meas_q > cfg_i.on_mv) begin
      charge_c = 1'b1;
    end
    cnt_c    = (charge_q && !charge_c) ? cfg_i.settle : settle_q;
    settle_c = !charge_c && (cnt_c != '0);
  end

  assign vema_c = 32'(vmul_q) + 32'(9'(9'd256 - 9'(av_q))) * 32'(volt_q) + 32'd128;

  // Clamp and find the curve segment that holds the voltage.
  always_comb begin
    vmax_c = {cfg_i.full_mv, 8'd0};
    vmin_c = {cfg_i.empty_mv, 8'd0};
    disp_c = (volt_q > vmax_c) ? vmax_c : volt_q;
    disp_c = (disp_c < vmin_c) ? vmin_c : disp_c;
    seg_c  = bfg_pkg::SEG_W'(bfg_pkg::CURVE_N - 2);
    for (int i = bfg_pkg::CURVE_N - 2; i >= 0; i--) begin
      if (disp_c >= {bfg_pkg::CURVE_MV[i+1], 8'd0}) seg_c = bfg_pkg::SEG_W'(i);
    end
    seg1_c = seg_c + 1'b1;
  end

  always_comb begin
    yr_c = 20'(num_q) + 20'({mvd_q, 7'd0});
    q_c  = 27'(yr_c[19:8]) * 27'(bfg_pkg::seg_recip(mvd_q));
  end

  assign pema_c = 25'(pmul_q) + 25'(9'(9'd256 - 9'(ap_q))) * 25'(pct_q) + 25'd128;

  always_comb begin
    base_c = {1'b0, shown_q, 8'd0};
    slew_c = pct_q;
    if (charge_q) begin
      if (16'(pct_q) + 16'd13 < base_c) slew_c = bfg_pkg::PF_W'(base_c - 16'd13);
    end else if (16'(pct_q) > base_c + 16'd256) begin
      slew_c = bfg_pkg::PF_W'(base_c + 16'd256);
    end
  end

  always_comb begin
    shown_c = 8'((16'(pct_q) + 16'd128) >> 8);
    if (shown_c > 8'(bfg_pkg::PCT_MAX)) shown_c = 8'(bfg_pkg::PCT_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfg_pkg::ST_IDLE;
      charge_q    <= 1'b0;
      settle_q    <= '0;
      primed_q    <= 1'b0;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
      out_chg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bfg_pkg::ST_MODE) begin
        charge_q <= charge_c;
        settle_q <= settle_c ? cnt_c - 1'b1 : cnt_c;
      end
      if (commit) begin
        shown_q     <= shown_c[bfg_pkg::PCT_W-1:0];
        primed_q    <= 1'b1;
        out_valid_q <= 1'b1;
        out_chg_q   <= charge_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bfg_pkg::ST_IDLE: trim_q <= trim_c;
      bfg_pkg::ST_DIV:  avg_q <= div_c[SUM_W +: bfg_pkg::SAMPLE_W];
      bfg_pkg::ST_FIX:  if (rem_c >= USED_V) avg_q <= avg_q + 1'b1;
      bfg_pkg::ST_GAIN: meas_q <= meas_c;
      bfg_pkg::ST_MODE: begin
        if (charge_c) begin
          av_q <= bfg_pkg::AV_CHARGE;
          ap_q <= bfg_pkg::AP_CHARGE;
        end else if (settle_c) begin
          av_q <= bfg_pkg::AV_SETTLE;
          ap_q <= bfg_pkg::AP_SETTLE;
        end else begin
          av_q <= bfg_pkg::AV_DISCH;
          ap_q <= bfg_pkg::AP_DISCH;
        end
      end
      bfg_pkg::ST_VMUL: vmul_q <= 29'(av_q) * 29'({meas_q, 8'd0});
      bfg_pkg::ST_VEMA: volt_q <= primed_q ? vema_c[8 +: bfg_pkg::VF_W] : {meas_q, 8'd0};
      bfg_pkg::ST_CURVE: begin
        direct_q <= 1'b0;
        rawd_q   <= '0;
        if (disp_c >= {bfg_pkg::CURVE_MV[0], 8'd0}) begin
          direct_q <= 1'b1;
          rawd_q   <= bfg_pkg::PCT_MAX;
        end else if (disp_c <= {bfg_pkg::CURVE_MV[bfg_pkg::CURVE_N-1], 8'd0}) begin
          direct_q <= 1'b1;
        end
        diff_q <= 15'(disp_c - {bfg_pkg::CURVE_MV[seg1_c], 8'd0});
        dp_q   <= bfg_pkg::DP_W'(bfg_pkg::CURVE_PCT[seg_c] - bfg_pkg::CURVE_PCT[seg1_c]);
        mvd_q  <= bfg_pkg::MVD_W'(bfg_pkg::CURVE_MV[seg_c] - bfg_pkg::CURVE_MV[seg1_c]);
        plo_q  <= bfg_pkg::CURVE_PCT[seg1_c];
      end
      bfg_pkg::ST_CMUL: num_q <= 19'(diff_q) * 19'(dp_q);
      bfg_pkg::ST_CDIV: raw_q <= direct_q ? rawd_q
                                          : plo_q + q_c[bfg_pkg::RECIP_SH +: bfg_pkg::PCT_W];
      bfg_pkg::ST_PMUL: pmul_q <= 21'(ap_q) * 21'({raw_q, 8'd0});
      bfg_pkg::ST_PEMA: pct_q <= primed_q ? pema_c[8 +: bfg_pkg::PF_W] : {raw_q, 8'd0};
      bfg_pkg::ST_SLEW: if (primed_q) pct_q <= slew_c;
      bfg_pkg::ST_OUT:  if (commit) measured_mv_o <= meas_q;
      default: ;
    endcase
  end

  // The charging flag is held with the result so a stalled item stays stable
  // while the next reading is already being worked on.
  assign out_valid_o      = out_valid_q;
  assign charge_percent_o = shown_q;
  assign charging_o       = out_chg_q;

  `BFG_ASSERT(a_pct_max, out_valid_q |-> (shown_q <= bfg_pkg::PCT_MAX), "percent above 100")
  `BFG_ASSERT(a_primed, out_valid_q |-> primed_q, "result shown before filters were loaded")
  `BFG_ASSERT(a_out_wait, ((state_q == bfg_pkg::ST_OUT) && out_valid_q && out_stall_i) |=> (state_q == bfg_pkg::ST_OUT), "new result overwrote a stalled one")

endmodule

@@ tb/bfg_checker.sv @@
module bfg_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [bfg_pkg::SAMPLE_W-1:0]   sample_mv_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [bfg_pkg::PCT_W-1:0]      charge_percent_i,
  input  logic                           charging_i,
  input  logic [bfg_pkg::MV_W-1:0]       measured_mv_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int READING_LEN = 16;
  localparam int KEPT = READING_LEN - 4;

  typedef struct packed {
    logic [bfg_pkg::PCT_W-1:0] pct;
    logic                      chg;
    logic [bfg_pkg::MV_W-1:0]  mv;
  } gauge_result_t;

  gauge_result_t expected_readings[$];

  logic [bfg_pkg::GAIN_W-1:0]   gain;
  logic [bfg_pkg::MV_W-1:0]     on_mv, off_mv, full_lim, empty_lim;
  logic [bfg_pkg::SETTLE_W-1:0] settle_len;

  int          idx, acc_sum, lo0, lo1, hi0, hi1;
  longint      vfilt, pfilt;
  int          shown, settle_left;
  logic        charging, primed;

  assign pending_o = expected_readings.size();

  function automatic longint smooth(longint f, longint x, longint a);
    return (a * x + (256 - a) * f + 128) >>> 8;
  endfunction

  // Piecewise-linear voltage to percent lookup, v in Q8 mV, ties round up.
  function automatic longint curve_pct(longint v);
    longint lo, den, dp;
    if (v >= longint'(bfg_pkg::CURVE_MV[0]) * 256) return 100;
    if (v <= longint'(bfg_pkg::CURVE_MV[bfg_pkg::CURVE_N-1]) * 256) return 0;
    for (int i = 0; i < bfg_pkg::CURVE_N - 1; i++) begin
      lo = longint'(bfg_pkg::CURVE_MV[i+1]) * 256;
      if (v >= lo) begin
        den = (longint'(bfg_pkg::CURVE_MV[i]) - longint'(bfg_pkg::CURVE_MV[i+1])) * 256;
        dp = longint'(bfg_pkg::CURVE_PCT[i]) - longint'(bfg_pkg::CURVE_PCT[i+1]);
        return longint'(bfg_pkg::CURVE_PCT[i+1]) + ((v - lo) * dp + den / 2) / den;
      end
    end
    return 0;
  endfunction

  task automatic clear_reading();
    idx = 0;
    acc_sum = 0;
    lo0 = 4095; lo1 = 4095;
    hi0 = 0; hi1 = 0;
  endtask

  task automatic take_sample(int s);
    longint avg, meas, disp, raw, base;
    int av, ap;
    logic was, slow;
    gauge_result_t r;
    acc_sum += s;
    if (s < lo0) begin
      lo1 = lo0; lo0 = s;
    end else if (s < lo1) begin
      lo1 = s;
    end
    if (s > hi0) begin
      hi1 = hi0; hi0 = s;
    end else if (s > hi1) begin
      hi1 = s;
    end
    if (idx + 1 < READING_LEN) begin
      idx++;
      return;
    end
    avg = (acc_sum - lo0 - lo1 - hi0 - hi1) / KEPT;
    clear_reading();
    meas = (avg * gain + 8192) >>> 14;
    if (meas > bfg_pkg::MV_MAX) meas = bfg_pkg::MV_MAX;

    was = charging;
    if (charging) begin
      if (meas < off_mv) charging = 1'b0;
    end else if (meas > on_mv) begin
      charging = 1'b1;
    end
    if (was && !charging) settle_left = settle_len;
    slow = !charging && settle_left > 0;
    if (slow) settle_left--;
    if (charging) begin
      av = bfg_pkg::AV_CHARGE; ap = bfg_pkg::AP_CHARGE;
    end else if (slow) begin
      av = bfg_pkg::AV_SETTLE; ap = bfg_pkg::AP_SETTLE;
    end else begin
      av = bfg_pkg::AV_DISCH; ap = bfg_pkg::AP_DISCH;
    end

    vfilt = primed ? smooth(vfilt, meas * 256, av) : meas * 256;
    disp = vfilt;
    // Full clamp first, so a crossed empty limit wins.
    if (disp > longint'(full_lim) * 256) disp = longint'(full_lim) * 256;
    if (disp < longint'(empty_lim) * 256) disp = longint'(empty_lim) * 256;
    raw = curve_pct(disp);

    if (!primed) begin
      pfilt = raw * 256;
      primed = 1'b1;
    end else begin
      pfilt = smooth(pfilt, raw * 256, ap);
      base = longint'(shown) * 256;
      if (charging && pfilt < base - 13) pfilt = base - 13;
      if (!charging && pfilt > base + 256) pfilt = base + 256;
    end
    shown = int'((pfilt + 128) >>> 8);
    if (shown > 100) shown = 100;

    r.pct = shown[bfg_pkg::PCT_W-1:0];
    r.chg = charging;
    r.mv = meas[bfg_pkg::MV_W-1:0];
    expected_readings.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gauge_result_t e;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      gain <= 16'd49152; on_mv <= 14'd4000; off_mv <= 14'd3950;
      settle_len <= 8'd36; full_lim <= 14'd4050; empty_lim <= 14'd3000;
      clear_reading();
      vfilt = 0; pfilt = 0; shown = 0; settle_left = 0;
      charging = 1'b0; primed = 1'b0;
      fail_count_o <= 0;
      expected_readings.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bfg_pkg::CFG_GAIN:       gain <= cfg_wdata_i;
          bfg_pkg::CFG_CHARGE_ON:  on_mv <= cfg_wdata_i[bfg_pkg::MV_W-1:0];
          bfg_pkg::CFG_CHARGE_OFF: off_mv <= cfg_wdata_i[bfg_pkg::MV_W-1:0];
          bfg_pkg::CFG_SETTLE:     settle_len <= cfg_wdata_i[bfg_pkg::SETTLE_W-1:0];
          bfg_pkg::CFG_FULL:       full_lim <= cfg_wdata_i[bfg_pkg::MV_W-1:0];
          bfg_pkg::CFG_EMPTY:      empty_lim <= cfg_wdata_i[bfg_pkg::MV_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) take_sample(sample_mv_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result: pct %0d charging %0d mv %0d",
                 charge_percent_i, charging_i, measured_mv_i);
          errs++;
        end else begin
          e = expected_readings.pop_front();
          if (charge_percent_i !== e.pct) begin
            $error("charge_percent expected %0d actual %0d", e.pct, charge_percent_i);
            errs++;
          end
          if (charging_i !== e.chg) begin
            $error("charging expected %0d actual %0d", e.chg, charging_i);
            errs++;
          end
          if (measured_mv_i !== e.mv) begin
            $error("measured_mv expected %0d actual %0d", e.mv, measured_mv_i);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

@@ tb/tb_battery_fuel_gauge_filter.sv @@
module tb_battery_fuel_gauge_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [bfg_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [bfg_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [bfg_pkg::SAMPLE_W-1:0]   sample_mv_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [bfg_pkg::PCT_W-1:0]      charge_percent_o;
  logic                           charging_o;
  logic [bfg_pkg::MV_W-1:0]       measured_mv_o;

  int   fail_count, pending;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  int   quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  battery_fuel_gauge_filter u_top (.*);

  bfg_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .sample_mv_i,
    .out_valid_i(out_valid_o), .out_stall_i, .charge_percent_i(charge_percent_o),
    .charging_i(charging_o), .measured_mv_i(measured_mv_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: random stalls per item, plus one long hold on request.
  initial begin
    int n;
    logic v;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 3);
      if (hold_req) n = HOLD_CYCLES;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i) v = out_valid_o;
        @(posedge clk_i);
      end while (!v);
    end
  end

  task automatic send_sample(int s);
    int gap;
    logic st;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_mv_i <= s[bfg_pkg::SAMPLE_W-1:0];
    do begin
      @(negedge clk_i) st = in_stall_o;
      @(posedge clk_i);
    end while (st);
  endtask

  // One reading of 16 samples near a pin voltage, with occasional outliers.
  task automatic send_reading(int center, int spread);
    int s;
    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(0, 15) == 0) s = $urandom_range(0, 4095);
      else s = center + $urandom_range(0, 2 * spread) - spread;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      send_sample(s);
    end
  endtask

  task automatic write_reg(logic [bfg_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[bfg_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_all(int g, int on, int off, int st, int fu, int em);
    write_reg(bfg_pkg::CFG_GAIN, g);
    write_reg(bfg_pkg::CFG_CHARGE_ON, on);
    write_reg(bfg_pkg::CFG_CHARGE_OFF, off);
    write_reg(bfg_pkg::CFG_SETTLE, st);
    write_reg(bfg_pkg::CFG_FULL, fu);
    write_reg(bfg_pkg::CFG_EMPTY, em);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first reading primes the filters, then field extremes.
    for (int i = 0; i < 16; i++) send_sample(4095);
    for (int i = 0; i < 16; i++) send_sample(0);
    for (int i = 0; i < 16; i++) send_sample((i % 2) ? 4095 : i * 85);
    // Charge, then unplug into the settle window.
    for (int r = 0; r < 3; r++) send_reading(1400, 5);
    for (int r = 0; r < 3; r++) send_reading(1100, 5);
    drain();

    // Gain at maximum with full-scale samples, and writes past the list.
    write_reg(bfg_pkg::CFG_GAIN, 16'hFFFF);
    write_reg(3'd6, 16'h1234);
    write_reg(3'd7, 16'hFFFF);
    for (int i = 0; i < 16; i++) send_sample(4095);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_all(49152, 4000, 3950, 36, 4050, 3000);
        1: write_all(65535, 16383, 16383, 255, 16383, 16383);
        2: write_all(0, 0, 0, 0, 0, 0);
        3: write_all(49152, 3900, 3800, 0, 3200, 3900);   // crossed clamps
        4: write_all(49152, 4000, 3950, 255, 4050, 3000);
        default: write_all($urandom_range(40000, 60000), $urandom_range(3700, 4100),
                           $urandom_range(3600, 4000), $urandom_range(0, 40),
                           $urandom_range(3500, 16383), $urandom_range(0, 3600));
      endcase
      no_idle <= (p == 5);
      // The hold request stays up until the fifth reading of this pass starts,
      // so the result side enters its long hold after the first result is taken.
      if (p == 4) hold_req <= 1'b1;
      for (int r = 0; r < 8; r++) begin
        if (p == 4 && r == 4) hold_req <= 1'b0;
        if ($urandom_range(0, 5) == 0) send_reading($urandom_range(0, 4095), 2048);
        else send_reading($urandom_range(900, 1450), $urandom_range(0, 40));
      end
      drain();
    end
    no_idle <= 1'b0;

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
